[rtl/core/assert_macros.svh]
// Assertion shorthands used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssc assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define SSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssc assertion failed: next-cycle implication");

`endif

[rtl/core/ssc_pkg.sv]
`default_nettype none

package ssc_pkg;

    // Default length of the segment shift chain
    localparam int FRAME_BITS_DEF = 32;

    // Width of the segment words from the digit ROMs
    localparam int ROM_W = 32;

    typedef logic [3:0] nibble_t;
    typedef nibble_t [3:0] digit_vec_t;

    // Input word operation codes
    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_INCREASE = 3'd1,
        MODE_ZERO     = 3'd2,
        MODE_SET      = 3'd3,
        MODE_REFRESH  = 3'd4
    } mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_LIMIT_DIGIT0   = 3'd0,
        REG_LIMIT_DIGIT1   = 3'd1,
        REG_LIMIT_DIGIT2   = 3'd2,
        REG_LIMIT_DIGIT3   = 3'd3,
        REG_SHOW_ZERO_MASK = 3'd4,
        REG_POINT_MASK     = 3'd5
    } cfg_reg_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam nibble_t LIMIT_RST     = 4'd9;
    localparam nibble_t SHOW_ZERO_RST = 4'hF;
    localparam nibble_t POINT_RST     = 4'h0;

    // Frame bit lit by each digit's decimal point
    localparam int POINT_POS [4] = '{8, 13, 18, 23};

    // Segment word for one digit position; values above nine show blank
    function automatic logic [ROM_W-1:0] rom_word(input logic [1:0] which, input nibble_t d);
        logic [ROM_W-1:0] w;
        w = '0;
        case (which)
            2'd0:
            begin
                case (d)
                    4'd0: w = 32'h0000_02F8;
                    4'd1: w = 32'h0000_0060;
                    4'd2: w = 32'h0000_04D8;
                    4'd3: w = 32'h0000_04F0;
                    4'd4: w = 32'h0000_0660;
                    4'd5: w = 32'h0000_06B0;
                    4'd6: w = 32'h0000_06B8;
                    4'd7: w = 32'h0000_00E0;
                    4'd8: w = 32'h0000_06F8;
                    4'd9: w = 32'h0000_06F0;
                    default: w = '0;
                endcase
            end
            2'd1:
            begin
                case (d)
                    4'd0: w = 32'h0000_5807;
                    4'd1: w = 32'h0000_0804;
                    4'd2: w = 32'h0000_9803;
                    4'd3: w = 32'h0000_9806;
                    4'd4: w = 32'h0000_C804;
                    4'd5: w = 32'h0000_D006;
                    4'd6: w = 32'h0000_D007;
                    4'd7: w = 32'h0000_1804;
                    4'd8: w = 32'h0000_D807;
                    4'd9: w = 32'h0000_D806;
                    default: w = '0;
                endcase
            end
            2'd2:
            begin
                case (d)
                    4'd0: w = 32'hE00B_0000;
                    4'd1: w = 32'h8001_0000;
                    4'd2: w = 32'h6013_0000;
                    4'd3: w = 32'hC013_0000;
                    4'd4: w = 32'h8019_0000;
                    4'd5: w = 32'hC01A_0000;
                    4'd6: w = 32'hE01A_0000;
                    4'd7: w = 32'h8003_0000;
                    4'd8: w = 32'hE01B_0000;
                    4'd9: w = 32'hC01B_0000;
                    default: w = '0;
                endcase
            end
            default:
            begin
                case (d)
                    4'd0: w = 32'h1D60_0000;
                    4'd1: w = 32'h1020_0000;
                    4'd2: w = 32'h0E60_0000;
                    4'd3: w = 32'h1A60_0000;
                    4'd4: w = 32'h1320_0000;
                    4'd5: w = 32'h1B40_0000;
                    4'd6: w = 32'h1F40_0000;
                    4'd7: w = 32'h1060_0000;
                    4'd8: w = 32'h1F60_0000;
                    4'd9: w = 32'h1B60_0000;
                    default: w = '0;
                endcase
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ssc_frame_build.sv]
`default_nettype none

module ssc_frame_build
    import ssc_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  wire digit_vec_t              digits,
    input  wire nibble_t                 show_zero_mask,
    input  wire nibble_t                 point_mask,
    output logic [FRAME_BITS-1:0]        frame
);

    logic [ROM_W-1:0]   base;
    logic [2*ROM_W-1:0] wide;

    // Merge decimal points and segment words, blank zero digits unless shown
    always_comb
    begin
        base = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (point_mask[i])
            begin
                base[POINT_POS[i]] = 1'b1;
            end
            if (!(digits[i] == 4'd0 && !show_zero_mask[i]))
            begin
                base = base | rom_word(2'(i), digits[i]);
            end
        end
    end

    // Fit the 32-bit word to the chain length; extra chain bits shift out as zero
    assign wide  = {{ROM_W{1'b0}}, base};
    assign frame = wide[FRAME_BITS-1:0];

endmodule

`default_nettype wire

[rtl/core/seven_segment_counter_serializer.sv]
// Four-digit display counter with a serial segment driver.
//
// Input channel (in_valid / in_stall) carries one word per command: mode plus
// the four set_digit values. Output channel (out_valid / out_stall) returns one
// result word per input word: carry_out, count_value and the serial pins
// ser_data, ser_clock, ser_latch with busy_res. A tick word shifts one frame bit,
// so a frame of FRAME_BITS bits plus its latch takes FRAME_BITS + 1 tick words.
// Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are always
// taken and belong between commands.
// Each result is registered; it shows the cycle after its word is taken.
// Throughput: one word per cycle unless stalled; one output register stage.
// While the receiver stalls a held result, in_stall rises in the same cycle and
// the held result stays unchanged; a free output register lets the next word in.
// Reset: digits zero, a refresh pending, the serializer idle, limits 9, all zero
// digits shown, decimal points off, no result word pending.

`default_nettype none

module seven_segment_counter_serializer
    import ssc_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  wire                    clk,
    input  wire                    rst_n,

    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire [2:0]              mode,
    input  wire [3:0]              set_digit0,
    input  wire [3:0]              set_digit1,
    input  wire [3:0]              set_digit2,
    input  wire [3:0]              set_digit3,

    output logic                   out_valid,
    input  wire                    out_stall,
    output logic                   carry_out,
    output logic [13:0]            count_value,
    output logic                   ser_data,
    output logic                   ser_clock,
    output logic                   ser_latch,
    output logic                   busy_res,

    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(FRAME_BITS + 2);
    localparam logic [IDX_W-1:0] IDX_LATCH = IDX_W'(FRAME_BITS);
    localparam logic [IDX_W-1:0] IDX_IDLE  = IDX_W'(FRAME_BITS + 1);

    // Configuration registers
    digit_vec_t              limit_reg;
    nibble_t                 show_zero_reg;
    nibble_t                 point_reg;

    // Block state
    digit_vec_t              digit_reg;
    digit_vec_t              digit_next;
    logic                    pend_reg;
    logic                    pend_next;
    logic [FRAME_BITS-1:0]   frame_reg;
    logic [FRAME_BITS-1:0]   frame_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;

    // Output register
    logic                    out_valid_reg;
    logic                    carry_reg;
    logic [13:0]             count_reg;
    logic                    data_reg;
    logic                    sclk_reg;
    logic                    latch_reg;
    logic                    busy_reg;

    logic                    carry_next;
    logic                    data_next;
    logic                    sclk_next;
    logic                    latch_next;
    logic [14:0]             count_sum;
    logic [FRAME_BITS-1:0]   built_frame;
    logic [8:0]              lo_pair;
    logic [8:0]              hi_pair;
    logic                    in_accept;

    // Advance a digit pair; result is {wrap, hi, lo}
    function automatic logic [8:0] bump_pair(input nibble_t lo, input nibble_t hi,
                                             input nibble_t lim_lo, input nibble_t lim_hi);
        logic [4:0] a;
        logic [4:0] b;
        logic [8:0] r;
        a = {1'b0, lo} + 5'd1;
        b = {1'b0, hi} + 5'd1;
        if (a > {1'b0, lim_lo})
        begin
            if (b > {1'b0, lim_hi})
            begin
                r = {1'b1, 4'd0, 4'd0};
            end
            else
            begin
                r = {1'b0, b[3:0], 4'd0};
            end
        end
        else
        begin
            r = {1'b0, hi, a[3:0]};
        end
        return r;
    endfunction

    ssc_frame_build #(
        .FRAME_BITS     (FRAME_BITS)
    ) u_frame_build (
        .digits         (digit_reg),
        .show_zero_mask (show_zero_reg),
        .point_mask     (point_reg),
        .frame          (built_frame)
    );

    // Handshake: take a word whenever the output register is free or draining
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign lo_pair = bump_pair(digit_reg[0], digit_reg[1], limit_reg[0], limit_reg[1]);
    assign hi_pair = bump_pair(digit_reg[2], digit_reg[3], limit_reg[2], limit_reg[3]);

    // Execute one command word
    always_comb
    begin
        digit_next = digit_reg;
        pend_next  = pend_reg;
        frame_next = frame_reg;
        idx_next   = idx_reg;
        carry_next = 1'b0;
        data_next  = 1'b0;
        sclk_next  = 1'b0;
        latch_next = 1'b0;
        case (mode)
            MODE_TICK:
            begin
                if (idx_reg < IDX_LATCH)
                begin
                    data_next  = frame_reg[0];
                    sclk_next  = 1'b1;
                    frame_next = frame_reg >> 1;
                    idx_next   = idx_reg + 1'b1;
                end
                else if (idx_reg == IDX_LATCH)
                begin
                    latch_next = 1'b1;
                    idx_next   = IDX_IDLE;
                end
            end
            MODE_INCREASE:
            begin
                pend_next     = 1'b1;
                digit_next[0] = lo_pair[3:0];
                digit_next[1] = lo_pair[7:4];
                if (lo_pair[8])
                begin
                    digit_next[2] = hi_pair[3:0];
                    digit_next[3] = hi_pair[7:4];
                    carry_next    = hi_pair[8];
                end
            end
            MODE_ZERO:
            begin
                pend_next  = 1'b1;
                digit_next = '0;
            end
            MODE_SET:
            begin
                digit_next = {set_digit3, set_digit2, set_digit1, set_digit0};
            end
            MODE_REFRESH:
            begin
                if (pend_reg && idx_reg > IDX_LATCH)
                begin
                    frame_next = built_frame;
                    pend_next  = 1'b0;
                    idx_next   = '0;
                end
            end
            default:
            begin
                digit_next = digit_reg;
            end
        endcase
    end

    // Decimal value of the digits after this word, modulo 2^14
    assign count_sum = 15'(digit_next[0])
                     + 15'(digit_next[1]) * 15'd10
                     + 15'(digit_next[2]) * 15'd100
                     + 15'(digit_next[3]) * 15'd1000;

    // Hold configuration; writes outside the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= {LIMIT_RST, LIMIT_RST, LIMIT_RST, LIMIT_RST};
            show_zero_reg <= SHOW_ZERO_RST;
            point_reg     <= POINT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LIMIT_DIGIT0:   limit_reg[0]  <= cfg_data;
                REG_LIMIT_DIGIT1:   limit_reg[1]  <= cfg_data;
                REG_LIMIT_DIGIT2:   limit_reg[2]  <= cfg_data;
                REG_LIMIT_DIGIT3:   limit_reg[3]  <= cfg_data;
                REG_SHOW_ZERO_MASK: show_zero_reg <= cfg_data;
                REG_POINT_MASK:     point_reg     <= cfg_data;
                default:            point_reg     <= point_reg;
            endcase
        end
    end

    // Advance block state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            pend_reg  <= 1'b1;
            frame_reg <= '0;
            idx_reg   <= IDX_IDLE;
        end
        else if (in_accept)
        begin
            digit_reg <= digit_next;
            pend_reg  <= pend_next;
            frame_reg <= frame_next;
            idx_reg   <= idx_next;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Output payload; hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            carry_reg <= carry_next;
            count_reg <= count_sum[13:0];
            data_reg  <= data_next;
            sclk_reg  <= sclk_next;
            latch_reg <= latch_next;
            busy_reg  <= (idx_next <= IDX_LATCH);
        end
    end

    assign out_valid   = out_valid_reg;
    assign carry_out   = carry_reg;
    assign count_value = count_reg;
    assign ser_data    = data_reg;
    assign ser_clock   = sclk_reg;
    assign ser_latch   = latch_reg;
    assign busy_res    = busy_reg;

endmodule

`default_nettype wire

[rtl/core/ssc_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module ssc_checker
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    out_valid,
    input  wire                    out_stall,
    input  wire                    carry_out,
    input  wire [13:0]             count_value,
    input  wire                    ser_data,
    input  wire                    ser_clock,
    input  wire                    ser_latch,
    input  wire                    busy_res
);

    // Whole result word as seen on the output port
    logic [18:0] result_word;

    assign result_word = {carry_out, count_value, ser_data, ser_clock, ser_latch, busy_res};

    // A stalled result word stays put
    `SSC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_word))

    // A full wrap leaves every digit at zero
    `SSC_ASSERT_IMP(a_carry_zero, out_valid && carry_out, count_value == 14'd0)

    // A shifted bit always leaves the latch still owed
    `SSC_ASSERT_IMP(a_clock_busy, out_valid && ser_clock, busy_res && !ser_latch)

    // The latch ends the frame
    `SSC_ASSERT_IMP(a_latch_idle, out_valid && ser_latch, !busy_res && !ser_data)

endmodule

bind seven_segment_counter_serializer ssc_checker u_ssc_checker (.*);

`default_nettype wire
